// File: rtl/core/rwh_pkg.sv
// Shared types and constants of the reciprocal word hash.
`default_nettype none
package rwh_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned HASH_W      = 64;
  localparam int unsigned DEN_W       = WORD_W + 1;
  localparam int unsigned FRAC_BITS   = 52;
  localparam int unsigned QUOT_W      = FRAC_BITS + 1;
  localparam int unsigned MIX_SHIFT   = 36;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [HASH_W-1:0] SEED_VALUE = 64'hfc64c9bd39ea2141;

  // One classified word waiting for the divider.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
    logic              trivial;
    logic [DEN_W-1:0]  den;
    logic [DEN_W-1:0]  rem0;
  } q_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_RND,
    BK_MIX
  } bk_state_t;

endpackage : rwh_pkg
`default_nettype wire

// File: rtl/core/reciprocal_word_hash.sv
// Top level of the reciprocal word hash: front end, queue and divider back end.
//
// Usage. Message words enter as requests on the input queue port: in_word with
// in_last marking the final word of a message; a request is taken at a clock
// edge where in_push is high and in_full is low. Each message gives exactly one
// 64-bit digest on the result port: out_digest is valid while out_empty is low
// and is taken at an edge where out_pop is high.
// Back-end steps. Each word passes through the back end in order: it is taken
// from the queue, the radix-2 divider works out its 52 fraction bits (one
// quotient bit per cycle), then come one rounding step and one mixing step.
// Words 0 and 1 skip the divider and the rounding step. With the back end
// idle, the digest of a message appears once its last word is mixed. A new
// word is taken only after the last is mixed; the divider loop sets the rate.
// The queue holds QUEUE_DEPTH classified words, so the sender can run ahead of
// the divider by that many requests.
// Reset (synchronous, rst_n low) empties the queue and the result register and
// loads the hash seed. If the receiver stalls, the digest is held; the back end
// then waits in its mixing step at the next last word, and the queue fills up.
`default_nettype none
module reciprocal_word_hash #(
  parameter int unsigned QUEUE_DEPTH = rwh_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [rwh_pkg::WORD_W-1:0]    in_word,
  input  wire logic                          in_last,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [rwh_pkg::HASH_W-1:0]         out_digest
);

  rwh_pkg::q_entry_t front_entry;
  rwh_pkg::q_entry_t q_data;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;

  // Classification happens combinationally on the way into the queue.
  rwh_front u_front (
    .word  (in_word),
    .last  (in_last),
    .entry (front_entry)
  );

  rwh_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  assign in_full = q_full;

  // The back end owns the running hash and the result register.
  rwh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .digest    (out_digest),
    .res_empty (out_empty),
    .res_pop   (out_pop)
  );

  // The back end never takes a word from an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
    else $error("back end popped an empty queue");

  // The queue can never be full and empty at once.
  assert property (@(posedge clk) disable iff (!rst_n) !(q_full && q_empty))
    else $error("queue reports full and empty together");

  // Reset leaves no digest pending.
  assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

endmodule : reciprocal_word_hash
`default_nettype wire

// File: rtl/core/rwh_front.sv
// Front end: classifies an incoming word and prepares the divider operands.
`default_nettype none
module rwh_front (
  input  wire logic [rwh_pkg::WORD_W-1:0] word,
  input  wire logic                       last,
  output rwh_pkg::q_entry_t               entry
);

  localparam int unsigned LEN_W = $clog2(rwh_pkg::DEN_W + 1);

  logic [rwh_pkg::DEN_W-1:0] den;
  logic [LEN_W-1:0]          len;
  logic [rwh_pkg::DEN_W:0]   pow;
  logic [rwh_pkg::DEN_W:0]   diff;

  // Bit length of the denominator, a plain priority encode.
  always_comb begin
    len = '0;
    for (int i = 0; i < int'(rwh_pkg::DEN_W); i++) begin
      if (den[i]) begin
        len = LEN_W'(i + 1);
      end
    end
  end

  assign den  = {word, 1'b0} - rwh_pkg::DEN_W'(1);
  assign pow  = (rwh_pkg::DEN_W+1)'(1) << len;
  // The first quotient bit is one; the remainder 2^len - den stays below den.
  assign diff = pow - {1'b0, den};

  always_comb begin
    entry.word    = word;
    entry.last    = last;
    entry.trivial = (word[rwh_pkg::WORD_W-1:1] == '0);
    entry.den     = den;
    entry.rem0    = diff[rwh_pkg::DEN_W-1:0];
  end

endmodule : rwh_front
`default_nettype wire

// File: rtl/core/rwh_fifo.sv
// Short register queue between the front end and the divider back end.
`default_nettype none
module rwh_fifo #(
  parameter int unsigned DEPTH = rwh_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire rwh_pkg::q_entry_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output rwh_pkg::q_entry_t      pop_data,
  output logic                   empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  rwh_pkg::q_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule : rwh_fifo
`default_nettype wire

// File: rtl/core/rwh_back.sv
// Back end: radix-2 reciprocal divider, rounding, hash mixing and result register.
`default_nettype none
module rwh_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rwh_pkg::q_entry_t           q_data,
  input  wire logic                        q_empty,
  output logic                             q_pop,
  output logic [rwh_pkg::HASH_W-1:0]       digest,
  output logic                             res_empty,
  input  wire logic                        res_pop
);

  localparam int unsigned CNT_W = $clog2(rwh_pkg::FRAC_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(rwh_pkg::FRAC_BITS - 1);
  localparam int unsigned DW = rwh_pkg::DEN_W;
  localparam int unsigned QW = rwh_pkg::QUOT_W;
  localparam int unsigned HW = rwh_pkg::HASH_W;
  localparam int unsigned WW = rwh_pkg::WORD_W;
  localparam int unsigned FB = rwh_pkg::FRAC_BITS;

  rwh_pkg::bk_state_t state_r, state_nxt;
  logic [DW-1:0]    den_r, den_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [QW-1:0]    q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WW-1:0]    word_r, word_nxt;
  logic             last_r, last_nxt;
  logic [HW-1:0]    hash_r, hash_nxt;
  logic [HW-1:0]    digest_r, digest_nxt;
  logic             ovalid_r, ovalid_nxt;

  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW:0]   rem_sub;
  logic [HW-1:0] h1, h2, h3;
  logic          out_free;

  assign rem_sh  = {rem_r, 1'b0};
  assign ge      = (rem_sh >= {1'b0, den_r});
  assign rem_sub = rem_sh - {1'b0, den_r};

  assign h1 = hash_r ^ {(HW-FB)'(0), q_r[FB-1:0]};
  assign h2 = h1 ^ (h1 << rwh_pkg::MIX_SHIFT);
  assign h3 = h2 ^ {(HW-WW)'(0), word_r};

  assign out_free  = !ovalid_r || res_pop;
  assign digest    = digest_r;
  assign res_empty = !ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    q_nxt      = q_r;
    cnt_nxt    = cnt_r;
    word_nxt   = word_r;
    last_nxt   = last_r;
    hash_nxt   = hash_r;
    digest_nxt = digest_r;
    ovalid_nxt = ovalid_r && !res_pop;
    q_pop      = 1'b0;
    unique case (state_r)
      rwh_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          den_nxt  = q_data.den;
          rem_nxt  = q_data.rem0;
          word_nxt = q_data.word;
          last_nxt = q_data.last;
          cnt_nxt  = '0;
          if (q_data.trivial) begin
            q_nxt     = '0;
            state_nxt = rwh_pkg::BK_MIX;
          end else begin
            q_nxt     = QW'(1);
            state_nxt = rwh_pkg::BK_DIV;
          end
        end
      end
      rwh_pkg::BK_DIV: begin
        rem_nxt = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        q_nxt   = {q_r[QW-2:0], ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = rwh_pkg::BK_RND;
        end
      end
      rwh_pkg::BK_RND: begin
        // Ties cannot happen since the divisor is odd.
        if (rem_sh > {1'b0, den_r}) begin
          q_nxt = q_r + QW'(1);
        end
        state_nxt = rwh_pkg::BK_MIX;
      end
      rwh_pkg::BK_MIX: begin
        if (!last_r) begin
          hash_nxt  = h3;
          state_nxt = rwh_pkg::BK_IDLE;
        end else if (out_free) begin
          digest_nxt = h3;
          ovalid_nxt = 1'b1;
          hash_nxt   = rwh_pkg::SEED_VALUE;
          state_nxt  = rwh_pkg::BK_IDLE;
        end
      end
      default: state_nxt = rwh_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rwh_pkg::BK_IDLE;
      hash_r   <= rwh_pkg::SEED_VALUE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      hash_r   <= hash_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    q_r      <= q_nxt;
    cnt_r    <= cnt_nxt;
    word_r   <= word_nxt;
    last_r   <= last_nxt;
    digest_r <= digest_nxt;
  end

endmodule : rwh_back
`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the reciprocal word hash block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Least number of words offered after the directed part.
  localparam int unsigned RANDOM_WORDS = 1725;
  // Longest idle draw of either side, in cycles.
  localparam int unsigned MAX_IDLE = 17;
  // Long receiver hold-off, long enough for the queue and back end to fill up.
  localparam int unsigned HOLD_CYCLES = 700;
  // Cycles allowed after the last digest for stray results to show up.
  localparam int unsigned SETTLE_CYCLES = 120;

  // Keeps the running hash of the message in flight and the digests that
  // completed messages are owed, oldest first.
  class digest_board;
    logic [rwh_pkg::HASH_W-1:0] chain;
    logic [rwh_pkg::HASH_W-1:0] awaited[$];
    int unsigned                faults;

    function new();
      chain  = rwh_pkg::SEED_VALUE;
      faults = 0;
    endfunction

    // Fraction bits of the nearest double to 1/(2w-1), by exact long division.
    function automatic logic [rwh_pkg::FRAC_BITS-1:0] reciprocal_fraction(
      logic [rwh_pkg::WORD_W-1:0] w
    );
      logic [rwh_pkg::DEN_W-1:0]  den;
      logic [rwh_pkg::DEN_W:0]    rem;
      logic [rwh_pkg::QUOT_W-1:0] quo;
      int unsigned                blen;
      int unsigned                b;
      if (w <= 1) begin
        return '0;
      end
      den  = {w, 1'b0} - 1'b1;
      blen = 0;
      for (b = 0; b < rwh_pkg::DEN_W; b++) begin
        if (den[b]) blen = b + 1;
      end
      // den lies between 2^(blen-1) and 2^blen, so the first quotient bit is one.
      rem = ({{rwh_pkg::DEN_W{1'b0}}, 1'b1} << blen) - den;
      quo = 1;
      for (b = 0; b < rwh_pkg::FRAC_BITS; b++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= den) begin
          rem    = rem - den;
          quo[0] = 1'b1;
        end
      end
      // Ties cannot happen because den is odd.
      if ((rem << 1) > den) quo = quo + 1'b1;
      return quo[rwh_pkg::FRAC_BITS-1:0];
    endfunction

    function void note_word(logic [rwh_pkg::WORD_W-1:0] w, logic l);
      logic [rwh_pkg::HASH_W-1:0] h;
      h = chain ^ {{(rwh_pkg::HASH_W-rwh_pkg::FRAC_BITS){1'b0}}, reciprocal_fraction(w)};
      h = h ^ (h << rwh_pkg::MIX_SHIFT);
      h = h ^ {{(rwh_pkg::HASH_W-rwh_pkg::WORD_W){1'b0}}, w};
      if (l) begin
        awaited.push_back(h);
        chain = rwh_pkg::SEED_VALUE;
      end else begin
        chain = h;
      end
    endfunction

    function void check_digest(logic [rwh_pkg::HASH_W-1:0] got);
      logic [rwh_pkg::HASH_W-1:0] want;
      if (awaited.size() == 0) begin
        $error("unexpected digest %h with no message outstanding", got);
        faults++;
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        $error("mismatch on field digest: expected %h, actual %h", want, got);
        faults++;
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  // All block inputs start at known values.
  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_push   = 1'b0;
  logic [rwh_pkg::WORD_W-1:0]   in_word   = '0;
  logic                         in_last   = 1'b0;
  logic                         out_pop   = 1'b0;
  logic                         in_full;
  logic                         out_empty;
  logic [rwh_pkg::HASH_W-1:0]   out_digest;

  digest_board board;

  // While a burst flag is set, that side runs back to back, bar the receiver hold-offs.
  bit burst_in  = 1'b0;
  bit burst_out = 1'b0;

  reciprocal_word_hash dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_word    (in_word),
    .in_last    (in_last),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_digest (out_digest)
  );

  // 4 ns clock period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offers one word and returns at the edge where the block takes it. The push
  // line is left high on return, so a following request with no idle gap keeps
  // it high without lowering and raising it in the same time step.
  task automatic offer_word(input logic [rwh_pkg::WORD_W-1:0] w, input logic l);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) burst_in = !burst_in;
    gap = burst_in ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_word <= w;
    in_last <= l;
    // Values seen right after the edge are the ones the block sampled.
    do @(posedge clk); while (in_full);
    board.note_word(w, l);
  endtask

  // Stops offering until every digest owed so far has been taken. At least one
  // edge passes, so the push line is never assigned twice in one step.
  task automatic wait_for_digests();
    in_push <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Receiver side: pops digests forever, with random stalls and two long
  // hold-offs during which the sender keeps offering words, so the block's
  // queue fills and in_full is exercised.
  task automatic drain_digests();
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    forever begin
      if ($urandom_range(0, 29) == 0) burst_out = !burst_out;
      stall = burst_out ? 0 : $urandom_range(0, MAX_IDLE);
      if (taken == 40 || taken == 200) stall = HOLD_CYCLES;
      if (stall != 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      board.check_digest(out_digest);
      taken++;
    end
  endtask

  // Word values weighted toward the interesting spots: the two words that skip
  // the divider, neighbors of powers of two (each divisor bit length), values
  // near the top of the range, and plain random words for bit coverage.
  function automatic logic [rwh_pkg::WORD_W-1:0] pick_word();
    logic [rwh_pkg::WORD_W-1:0] base;
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 3);
      1, 2: begin
        base = 32'd1 << $urandom_range(0, rwh_pkg::WORD_W - 1);
        return base + $urandom_range(0, 2) - 1;
      end
      3: return ~($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  // Short directed part: extremes of the word, the divider bypass words zero
  // and one both alone and inside longer messages, and top-bit boundaries.
  task automatic run_directed_words();
    offer_word(32'h0000_0000, 1'b1);
    offer_word(32'h0000_0001, 1'b1);
    offer_word(32'h0000_0002, 1'b1);
    offer_word(32'h0000_0003, 1'b1);
    offer_word(32'hFFFF_FFFF, 1'b1);
    offer_word(32'h8000_0000, 1'b1);
    offer_word(32'h7FFF_FFFF, 1'b1);
    offer_word(32'h8000_0001, 1'b1);
    // Bypass words in the middle of a message must still fold in the word.
    offer_word(32'h0000_0000, 1'b0);
    offer_word(32'h0000_0001, 1'b0);
    offer_word(32'h0000_0002, 1'b0);
    offer_word(32'h1234_5678, 1'b1);
    offer_word(32'hFFFF_FFFF, 1'b0);
    offer_word(32'h0000_0000, 1'b0);
    offer_word(32'hFFFF_FFFF, 1'b1);
    offer_word(32'h5555_5555, 1'b0);
    offer_word(32'hAAAA_AAAA, 1'b1);
    offer_word(32'h4000_0000, 1'b0);
    offer_word(32'h3FFF_FFFF, 1'b0);
    offer_word(32'hC000_0000, 1'b0);
    offer_word(32'h0001_0000, 1'b0);
    offer_word(32'h0000_FFFF, 1'b0);
    offer_word(32'h0000_0001, 1'b1);
  endtask

  // Random messages, mostly short so digests come often, a few long ones to
  // carry the running hash through many divider passes. Every message ends on
  // a last word, so no expectation is ever left hanging.
  task automatic run_random_messages();
    int unsigned sent;
    int unsigned msgs;
    int unsigned len;
    int unsigned roll;
    int unsigned k;
    sent = 0;
    msgs = 0;
    while (sent < RANDOM_WORDS) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) len = $urandom_range(1, 4);
      else if (roll < 95) len = $urandom_range(5, 12);
      else len = $urandom_range(13, 40);
      for (k = 0; k < len; k++) begin
        offer_word(pick_word(), k == len - 1);
      end
      sent += len;
      msgs++;
      // Let the block drain completely a couple of times mid-run.
      if (msgs == 60 || msgs == 250) wait_for_digests();
    end
  endtask

  initial begin
    board = new();
    // Synchronous reset, held low from the start and released at an edge.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    fork
      drain_digests();
    join_none
    run_directed_words();
    run_random_messages();
    in_push <= 1'b0;
    // Wait for the last digests, then give the block room to show any extra
    // result it should not produce.
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.faults == 0) begin
      $display("** reciprocal_word_hash: PASSED **");
    end else begin
      $display("** reciprocal_word_hash: FAILED **");
    end
    $finish;
  end

  // Watchdog: a time limit several times the slowest correct run.
  initial begin
    #4_000_000;
    $display("** reciprocal_word_hash: FAILED **");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/rwh_pkg.sv
rtl/core/rwh_front.sv
rtl/core/rwh_fifo.sv
rtl/core/rwh_back.sv
rtl/core/reciprocal_word_hash.sv
test/tb_top.sv
